/* hdl/rhf_pkg.sv */
// Shared types, constants and the reciprocal table of the RGBA hole filler.
package rhf_pkg;

  localparam int unsigned MaxWidthDef = 2048;
  localparam int unsigned MaxHeight   = 4096;

  localparam int unsigned CfgWidthW  = 12;
  localparam int unsigned CfgHeightW = 13;
  localparam int unsigned CfgDataW   = 13;
  localparam int unsigned CfgIdxW    = 1;

  localparam logic [CfgWidthW-1:0]  WidthReset  = 12'd640;
  localparam logic [CfgHeightW-1:0] HeightReset = 13'd480;

  localparam logic [7:0] AlphaOpaque = 8'd255;
  localparam logic [7:0] AlphaHole   = 8'd0;

  // Sums of up to eight 8-bit samples and the count of opaque neighbors.
  localparam int unsigned SumW   = 11;
  localparam int unsigned CountW = 4;
  localparam int unsigned RecipW = 17;
  localparam int unsigned RecipShift = 16;
  localparam int unsigned ProdW  = SumW + RecipW;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_e;

  // Packed so that channel zero sits in the low byte.
  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] c2;
    logic [7:0] c1;
    logic [7:0] c0;
  } pixel_t;

  typedef struct packed {
    logic [SumW-1:0]   s0;
    logic [SumW-1:0]   s1;
    logic [SumW-1:0]   s2;
    logic [CountW-1:0] cnt;
    pixel_t            center;
  } win_sum_t;

  // Rounded-up 2^16 / n. For sums below 2048 the product shifted down by
  // 16 equals the truncated quotient for every n from 1 to 8.
  function automatic logic [RecipW-1:0] recip(input logic [CountW-1:0] n);
    logic [RecipW-1:0] r;
    case (n)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13108;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9363;
      4'd8:    r = 17'd8192;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* hdl/rhf_line_store.sv */
// Two synchronous line memories holding the pixels one and two rows back.
module rhf_line_store #(
  parameter int unsigned LINE_LEN = rhf_pkg::MaxWidthDef,
  parameter int unsigned AW = $clog2(LINE_LEN)
) (
  input  logic            clk_i,
  input  logic            rd_en_i,
  input  logic [AW-1:0]   rd_addr_i,
  input  logic            wr_en_i,
  input  logic [AW-1:0]   wr_addr_i,
  input  rhf_pkg::pixel_t wr_pix_i,
  output rhf_pkg::pixel_t rd_upper_o,
  output rhf_pkg::pixel_t rd_middle_o
);
  import rhf_pkg::*;

  pixel_t mem_upper [LINE_LEN];
  pixel_t mem_middle [LINE_LEN];
  pixel_t rd_upper_q;
  pixel_t rd_middle_q;

  // The middle row moves up as the new pixel takes its place.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_upper[wr_addr_i] <= rd_middle_q;
    end
    if (rd_en_i) begin
      rd_upper_q <= mem_upper[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_middle[wr_addr_i] <= wr_pix_i;
    end
    if (rd_en_i) begin
      rd_middle_q <= mem_middle[rd_addr_i];
    end
  end

  assign rd_upper_o  = rd_upper_q;
  assign rd_middle_o = rd_middle_q;

endmodule

/* hdl/rhf_window.sv */
// 3x3 pixel window with registered masked sums over its opaque pixels.
module rhf_window (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              shift_i,
  input  rhf_pkg::pixel_t   upper_i,
  input  rhf_pkg::pixel_t   middle_i,
  input  rhf_pkg::pixel_t   lower_i,
  output rhf_pkg::win_sum_t sum_o
);
  import rhf_pkg::*;

  pixel_t   win_q [3][3];
  pixel_t   win_d [3][3];
  win_sum_t sum_d;
  win_sum_t sum_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r][0] = win_q[r][1];
      win_d[r][1] = win_q[r][2];
    end
    win_d[0][2] = upper_i;
    win_d[1][2] = middle_i;
    win_d[2][2] = lower_i;
  end

  always_comb begin
    sum_d = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (win_d[r][c].alpha == AlphaOpaque) begin
          sum_d.s0  = sum_d.s0 + SumW'(win_d[r][c].c0);
          sum_d.s1  = sum_d.s1 + SumW'(win_d[r][c].c1);
          sum_d.s2  = sum_d.s2 + SumW'(win_d[r][c].c2);
          sum_d.cnt = sum_d.cnt + CountW'(1);
        end
      end
    end
    sum_d.center = win_d[1][1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
      sum_q <= '0;
    end else if (shift_i) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= win_d[r][c];
        end
      end
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

/* hdl/rhf_mean_div.sv */
// Per-channel mean by reciprocal multiply and the fill decision.
module rhf_mean_div (
  input  rhf_pkg::win_sum_t sum_i,
  input  logic              interior_i,
  output rhf_pkg::pixel_t   pix_o
);
  import rhf_pkg::*;

  logic [RecipW-1:0] rcp;
  logic [ProdW-1:0]  p0;
  logic [ProdW-1:0]  p1;
  logic [ProdW-1:0]  p2;
  logic              fill;

  assign rcp = recip(sum_i.cnt);
  assign p0  = ProdW'(sum_i.s0) * ProdW'(rcp);
  assign p1  = ProdW'(sum_i.s1) * ProdW'(rcp);
  assign p2  = ProdW'(sum_i.s2) * ProdW'(rcp);

  assign fill = interior_i && (sum_i.center.alpha == AlphaHole) && (sum_i.cnt != '0);

  always_comb begin
    if (fill) begin
      pix_o.c0    = p0[RecipShift +: 8];
      pix_o.c1    = p1[RecipShift +: 8];
      pix_o.c2    = p2[RecipShift +: 8];
      pix_o.alpha = AlphaOpaque;
    end else begin
      pix_o = sum_i.center;
    end
  end

endmodule

/* hdl/rgba_hole_fill_3x3_mean_unit.sv */
// Top level of the RGBA hole filler: control, counters, config and output word.
//
// Usage: pixels of one frame arrive in raster order on the input channel
// (in_valid_i / in_stall_o). Each interior pixel with alpha 0 is replaced by
// the truncated per-channel mean of its opaque 3x3 neighbors, if any; alpha 255.
// The result word for a pixel leaves on the output channel (out_valid_o /
// out_stall_i) when the item one row plus one pixel later has been taken,
// so the first frame_width + 1 items give no word. After the last pixel,
// flush items (is_flush_i high) drain the remaining words; frame_end_o marks
// the last pixel, after which a new frame starts. A flush item within the
// frame is taken and dropped.
// Timing: one item is in work at a time. An item that gives no word takes a
// line memory read, then the window shift and write back. One that gives a
// word takes these steps too, and the masked sums are registered with the
// window; then the reciprocal multiply loads the output register. The
// output register lets the next item in while a word waits; a stalled
// receiver holds the block only when a second word is ready.
// Reset clears the counters, the window and the registers to width 640 and
// height 480. Line memories are not cleared. A register write restarts the frame.
module rgba_hole_fill_3x3_mean_unit #(
  parameter int unsigned LINE_LEN = rhf_pkg::MaxWidthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rhf_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [rhf_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           is_flush_i,
  input  logic [7:0]                     chan_zero_i,
  input  logic [7:0]                     chan_one_i,
  input  logic [7:0]                     chan_two_i,
  input  logic [7:0]                     alpha_in_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     out_zero_o,
  output logic [7:0]                     out_one_o,
  output logic [7:0]                     out_two_o,
  output logic [7:0]                     out_alpha_o,
  output logic                           frame_end_o
);
  import rhf_pkg::*;

  localparam int unsigned CW = $clog2(LINE_LEN);
  localparam int unsigned EW = CW + 1;
  localparam int unsigned HW = CfgHeightW;
  localparam int unsigned RW = CfgHeightW - 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_FILL
  } state_e;

  state_e                state_q;
  logic [CfgWidthW-1:0]  cfg_width_q;
  logic [CfgHeightW-1:0] cfg_height_q;
  logic [CW-1:0]         in_col_q;
  logic [HW-1:0]         in_row_q;
  logic [CW-1:0]         out_col_q;
  logic [RW-1:0]         out_row_q;
  pixel_t                pix_q;
  logic [CW-1:0]         wr_addr_q;
  logic                  emit_q;
  logic                  interior_q;
  logic                  last_q;
  logic                  out_valid_q;
  pixel_t                out_pix_q;
  logic                  out_end_q;

  logic [EW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic [EW-1:0] in_col_ext;
  logic [EW-1:0] out_col_ext;
  logic [HW-1:0] out_row_ext;
  logic          full;
  logic          in_wrap;
  logic          out_wrap;
  logic          frame_last;
  logic          emits;
  logic          interior;
  logic          in_accept;
  logic          take;
  logic          out_free;
  pixel_t        in_pix;
  pixel_t        rd_upper;
  pixel_t        rd_middle;
  pixel_t        fill_pix;
  win_sum_t      win_sum;

  // Registers outside their range are saturated.
  always_comb begin
    if (cfg_width_q < CfgWidthW'(3)) begin
      eff_w = EW'(3);
    end else if (32'(cfg_width_q) > 32'(LINE_LEN)) begin
      eff_w = EW'(LINE_LEN);
    end else begin
      eff_w = EW'(cfg_width_q);
    end
    if (cfg_height_q < HW'(3)) begin
      eff_h = HW'(3);
    end else if (32'(cfg_height_q) > 32'(MaxHeight)) begin
      eff_h = HW'(MaxHeight);
    end else begin
      eff_h = cfg_height_q;
    end
  end

  assign in_col_ext  = {1'b0, in_col_q};
  assign out_col_ext = {1'b0, out_col_q};
  assign out_row_ext = {1'b0, out_row_q};

  // All pixels of the frame are in once the row count reaches the height.
  assign full       = in_row_q >= eff_h;
  assign in_wrap    = (in_col_ext + EW'(1)) == eff_w;
  assign out_wrap   = (out_col_ext + EW'(1)) == eff_w;
  assign frame_last = out_wrap && ((out_row_ext + HW'(1)) == eff_h);
  // A word comes out once one row plus one pixel has been received.
  assign emits      = (in_row_q >= HW'(2)) || ((in_row_q == HW'(1)) && (in_col_q != '0));
  assign interior   = (out_row_q != '0) && ((out_row_ext + HW'(2)) <= eff_h)
                   && (out_col_q != '0) && ((out_col_ext + EW'(2)) <= eff_w);

  assign in_stall_o = state_q != ST_IDLE;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign take       = in_accept && !(is_flush_i && !full);
  assign out_free   = !out_valid_q || !out_stall_i;

  // During the drain the data of any item is replaced by a zero pixel.
  always_comb begin
    if (full) begin
      in_pix = '0;
    end else begin
      in_pix.c0    = chan_zero_i;
      in_pix.c1    = chan_one_i;
      in_pix.c2    = chan_two_i;
      in_pix.alpha = alpha_in_i;
    end
  end

  rhf_line_store #(
    .LINE_LEN (LINE_LEN),
    .AW       (CW)
  ) u_line_store (
    .clk_i       (clk_i),
    .rd_en_i     (take),
    .rd_addr_i   (in_col_q),
    .wr_en_i     (state_q == ST_READ),
    .wr_addr_i   (wr_addr_q),
    .wr_pix_i    (pix_q),
    .rd_upper_o  (rd_upper),
    .rd_middle_o (rd_middle)
  );

  rhf_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .shift_i  (state_q == ST_READ),
    .upper_i  (rd_upper),
    .middle_i (rd_middle),
    .lower_i  (pix_q),
    .sum_o    (win_sum)
  );

  rhf_mean_div u_mean_div (
    .sum_i      (win_sum),
    .interior_i (interior_q),
    .pix_o      (fill_pix)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cfg_width_q  <= WidthReset;
      cfg_height_q <= HeightReset;
      in_col_q     <= '0;
      in_row_q     <= '0;
      out_col_q    <= '0;
      out_row_q    <= '0;
      emit_q       <= 1'b0;
      interior_q   <= 1'b0;
      last_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      out_end_q    <= 1'b0;
      pix_q        <= '0;
      wr_addr_q    <= '0;
      out_pix_q    <= '0;
    end else begin
      // A taken word frees the output register unless a new word loads it.
      if (out_valid_q && !out_stall_i && (state_q != ST_FILL)) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        // Any register write restarts the frame.
        if (cfg_idx_i == CFG_FRAME_WIDTH) begin
          cfg_width_q <= cfg_data_i[CfgWidthW-1:0];
        end else begin
          cfg_height_q <= cfg_data_i[CfgHeightW-1:0];
        end
        in_col_q  <= '0;
        in_row_q  <= '0;
        out_col_q <= '0;
        out_row_q <= '0;
      end else if (take) begin
        if (emits && frame_last) begin
          in_col_q  <= '0;
          in_row_q  <= '0;
          out_col_q <= '0;
          out_row_q <= '0;
        end else begin
          if (in_wrap) begin
            in_col_q <= '0;
            in_row_q <= in_row_q + HW'(1);
          end else begin
            in_col_q <= in_col_q + CW'(1);
          end
          if (emits) begin
            if (out_wrap) begin
              out_col_q <= '0;
              out_row_q <= out_row_q + RW'(1);
            end else begin
              out_col_q <= out_col_q + CW'(1);
            end
          end
        end
      end

      case (state_q)
        ST_IDLE: begin
          if (take) begin
            pix_q      <= in_pix;
            wr_addr_q  <= in_col_q;
            emit_q     <= emits;
            interior_q <= interior;
            last_q     <= frame_last;
            state_q    <= ST_READ;
          end
        end
        ST_READ: begin
          state_q <= emit_q ? ST_FILL : ST_IDLE;
        end
        ST_FILL: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_pix_q   <= fill_pix;
            out_end_q   <= last_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_zero_o  = out_pix_q.c0;
  assign out_one_o   = out_pix_q.c1;
  assign out_two_o   = out_pix_q.c2;
  assign out_alpha_o = out_pix_q.alpha;
  assign frame_end_o = out_end_q;

endmodule
